### rtl/core/lpt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LFSR primitivity test: shared package
// Constants, command and verdict codes, the controller state type, the
// controller-to-datapath command and status structs, and the companion row
// function used by the datapath.
// ----------------------------------------------------------------------------
package lpt_pkg;

   // Largest supported LFSR length and the lower clamp of the order register.
   localparam logic [6:0] MAX_ORDER = 7'd64;
   localparam logic [6:0] MIN_ORDER = 7'd4;
   localparam logic [6:0] ORDER_RESET = 7'd8;

   // Column 0 of a matrix row is the most significant bit.
   localparam logic [63:0] TOP_BIT = 64'h8000_0000_0000_0000;

   // Input commands.
   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_TEST   = 2'd2;

   // Verdict codes.
   localparam logic [1:0] VERDICT_MAXIMAL   = 2'd0;
   localparam logic [1:0] VERDICT_EARLY     = 2'd1;
   localparam logic [1:0] VERDICT_NO_RETURN = 2'd2;
   localparam logic [1:0] VERDICT_COFACTOR  = 2'd3;

   // Reciprocal comparison codes.
   localparam logic [1:0] MIRROR_SYMMETRIC = 2'd0;
   localparam logic [1:0] MIRROR_LOW_SET   = 2'd1;
   localparam logic [1:0] MIRROR_LOW_CLEAR = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_FIND,
      ST_ROW_RD,
      ST_ROW_LAT,
      ST_SCAN,
      ST_DRAIN,
      ST_WRITE,
      ST_AFTER,
      ST_COF_START,
      ST_COF_END,
      ST_RESULT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       accept;
      logic       rd_bank;
      logic [5:0] rd_row;
      logic       wr_en;
      logic       wr_bank;
      logic       wr_shift;
      logic [5:0] row;
      logic       acc_clr;
      logic       op_latch;
      logic       op_shift;
      logic       scan;
      logic       e_load;
      logic [5:0] cof_index;
      logic [5:0] pos;
      logic       result_load;
      logic [1:0] verdict;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [6:0] order;
      logic [6:0] cof_count;
      logic       e_bit;
      logic       eq_first;
      logic       unit_row;
      logic       slot_free;
   } dp_status_type;

   // Row of the one-shift companion matrix for the given tap mask.
   function automatic logic [63:0] shift_row(input logic [5:0] row, input logic [6:0] n,
                                             input logic [63:0] taps);
      logic [63:0] r;
      if ({1'b0, row} == n - 7'd1) begin
         r = TOP_BIT;
      end else begin
         r = TOP_BIT >> ({1'b0, row} + 7'd1);
      end
      if (taps[row]) begin
         r = r | TOP_BIT;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### rtl/core/lpt_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LFSR primitivity test: datapath
// Holds the order register, the cofactor table, the two-bank matrix memory,
// the row accumulator, the row-0 checks, the reciprocal comparison and the
// result register.
// ----------------------------------------------------------------------------
module lpt_datapath #(
   parameter int MAX_COFACTORS = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   input  lpt_pkg::dp_cmd_type  cmd,
   output lpt_pkg::dp_status_type status,
   input  wire [1:0]            req_command,
   input  wire [63:0]           req_value,
   input  wire                  csr_write_enable,
   input  wire [6:0]            csr_write_data,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output logic                 rsp_is_maximal,
   output logic [1:0]           rsp_verdict,
   output logic [1:0]           rsp_mirror_kind,
   output logic                 rsp_table_overflow
);
   import lpt_pkg::*;

   localparam int KW = (MAX_COFACTORS > 1) ? $clog2(MAX_COFACTORS) : 1;
   localparam int CW = $clog2(MAX_COFACTORS + 1);

   logic [6:0]    order_ff;
   logic [6:0]    n_used;
   logic [63:0]   tap_ff;
   logic [63:0]   cof_table_ff [MAX_COFACTORS];
   logic [CW-1:0] cof_count_ff;
   logic          ovf_ff;
   logic [63:0]   e_ff;
   logic [63:0]   mem [128];
   logic [63:0]   rdata_ff;
   logic [63:0]   op_ff;
   logic [63:0]   acc_ff;
   logic          pend_ff;
   logic [5:0]    pend_col_ff;
   logic          eq_first_ff;
   logic          unit_ff;
   logic [63:0]   shift_cur;
   logic [63:0]   shift_first;
   logic [63:0]   wdata;
   logic [1:0]    mirror;
   logic          table_room;
   logic          rsp_valid_ff;
   logic          rsp_max_ff;
   logic [1:0]    rsp_verdict_ff;
   logic [1:0]    rsp_mirror_ff;
   logic          rsp_ovf_ff;

   // Order register, clamped to the supported range for use.
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_RESET;
      end else if (csr_write_enable) begin
         order_ff <= csr_write_data;
      end
   end

   always_comb begin
      if (order_ff < MIN_ORDER) begin
         n_used = MIN_ORDER;
      end else if (order_ff > MAX_ORDER) begin
         n_used = MAX_ORDER;
      end else begin
         n_used = order_ff;
      end
   end

   assign table_room = cof_count_ff < CW'(MAX_COFACTORS);

   // Cofactor list control and tap mask capture.
   always_ff @(posedge clock) begin
      if (reset) begin
         cof_count_ff <= '0;
         ovf_ff       <= 1'b0;
      end else if (cmd.accept) begin
         case (req_command)
            CMD_CLEAR: begin
               cof_count_ff <= '0;
               ovf_ff       <= 1'b0;
            end
            CMD_APPEND: begin
               if (table_room) begin
                  cof_count_ff <= cof_count_ff + CW'(1);
               end else begin
                  ovf_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // Cofactor table entries and the tap mask need no reset.
   always_ff @(posedge clock) begin
      if (cmd.accept && req_command == CMD_APPEND && table_room) begin
         cof_table_ff[cof_count_ff[KW-1:0]] <= req_value;
      end
      if (cmd.accept && req_command == CMD_TEST) begin
         tap_ff <= req_value;
      end
      if (cmd.e_load) begin
         e_ff <= cof_table_ff[cmd.cof_index[KW-1:0]];
      end
   end

   // Companion rows for the current row and for row 0.
   assign shift_cur   = shift_row(cmd.row, n_used, tap_ff);
   assign shift_first = shift_row(6'd0, n_used, tap_ff);
   assign wdata       = cmd.wr_shift ? shift_cur : acc_ff;

   // Matrix memory: two banks of 64 rows, one write and one registered read.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[{cmd.wr_bank, cmd.row}] <= wdata;
      end
      rdata_ff <= mem[{cmd.rd_bank, cmd.rd_row}];
   end

   // Operand row latch and row accumulator; read data arrives in the cycle
   // after its column was issued.
   always_ff @(posedge clock) begin
      if (cmd.op_latch) begin
         op_ff <= cmd.op_shift ? shift_cur : rdata_ff;
      end
      pend_col_ff <= cmd.rd_row;
      if (cmd.acc_clr) begin
         acc_ff <= '0;
      end else if (pend_ff && op_ff[~pend_col_ff]) begin
         acc_ff <= acc_ff ^ rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.scan;
      end
   end

   // Row-0 checks, taken whenever row 0 of a matrix is written.
   always_ff @(posedge clock) begin
      if (reset) begin
         eq_first_ff <= 1'b0;
         unit_ff     <= 1'b0;
      end else if (cmd.wr_en && cmd.row == 6'd0) begin
         eq_first_ff <= (wdata == shift_first);
         unit_ff     <= (wdata == TOP_BIT);
      end
   end

   // Reciprocal comparison: the lowest mismatching tap pair decides.
   always_comb begin
      logic lo;
      logic hi;
      mirror = MIRROR_SYMMETRIC;
      for (int k = 31; k >= 0; k--) begin
         lo = tap_ff[k];
         hi = tap_ff[6'(n_used - 7'(k) - 7'd2)];
         if (7'(k) < (n_used >> 1) && lo != hi) begin
            mirror = lo ? MIRROR_LOW_SET : MIRROR_LOW_CLEAR;
         end
      end
   end

   // Result register; it holds its transfer until the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.result_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         rsp_max_ff     <= (cmd.verdict == VERDICT_MAXIMAL);
         rsp_verdict_ff <= cmd.verdict;
         rsp_mirror_ff  <= mirror;
         rsp_ovf_ff     <= ovf_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_is_maximal     = rsp_max_ff;
   assign rsp_verdict        = rsp_verdict_ff;
   assign rsp_mirror_kind    = rsp_mirror_ff;
   assign rsp_table_overflow = rsp_ovf_ff;

   assign status.order     = n_used;
   assign status.cof_count = 7'(cof_count_ff);
   assign status.e_bit     = e_ff[cmd.pos];
   assign status.eq_first  = eq_first_ff;
   assign status.unit_row  = unit_ff;
   assign status.slot_free = !rsp_valid_ff || !rsp_stall;

endmodule
`default_nettype wire

### rtl/core/lpt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LFSR primitivity test: controller
// Sequences matrix loads, row-by-row GF(2) products, the squaring test, the
// square-and-multiply runs for each cofactor, and the result hand-off.
// ----------------------------------------------------------------------------
module lpt_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   input  wire [1:0]              req_command,
   output logic                   req_stall,
   output lpt_pkg::dp_cmd_type    cmd,
   input  lpt_pkg::dp_status_type status
);
   import lpt_pkg::*;

   state_type  state_ff, state_in;
   logic [6:0] row_ff, row_in;
   logic [6:0] col_ff, col_in;
   logic [6:0] sq_ff, sq_in;
   logic [6:0] k_ff, k_in;
   logic [5:0] pos_ff, pos_in;
   logic       bank_ff, bank_in;
   logic       mul_shift_ff, mul_shift_in;
   logic       cof_phase_ff, cof_phase_in;
   logic [1:0] verdict_ff, verdict_in;
   logic [6:0] n_last;

   assign n_last = status.order - 7'd1;

   // State and loop counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         sq_ff        <= '0;
         k_ff         <= '0;
         pos_ff       <= '0;
         bank_ff      <= 1'b0;
         mul_shift_ff <= 1'b0;
         cof_phase_ff <= 1'b0;
         verdict_ff   <= VERDICT_MAXIMAL;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         sq_ff        <= sq_in;
         k_ff         <= k_in;
         pos_ff       <= pos_in;
         bank_ff      <= bank_in;
         mul_shift_ff <= mul_shift_in;
         cof_phase_ff <= cof_phase_in;
         verdict_ff   <= verdict_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      sq_in         = sq_ff;
      k_in          = k_ff;
      pos_in        = pos_ff;
      bank_in       = bank_ff;
      mul_shift_in  = mul_shift_ff;
      cof_phase_in  = cof_phase_ff;
      verdict_in    = verdict_ff;
      req_stall     = 1'b1;
      cmd           = '0;
      cmd.rd_bank   = bank_ff;
      cmd.rd_row    = row_ff[5:0];
      cmd.wr_bank   = bank_ff;
      cmd.row       = row_ff[5:0];
      cmd.cof_index = k_ff[5:0];
      cmd.pos       = pos_ff;
      cmd.verdict   = verdict_ff;

      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (req_valid && req_command == CMD_TEST) begin
               row_in       = '0;
               cof_phase_in = 1'b0;
               state_in     = ST_LOAD;
            end
         end
         // Write the companion matrix into the current bank.
         ST_LOAD: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_shift = 1'b1;
            if (row_ff == n_last) begin
               row_in = '0;
               if (!cof_phase_ff) begin
                  sq_in        = 7'd1;
                  mul_shift_in = 1'b0;
                  state_in     = ST_ROW_RD;
               end else begin
                  pos_in   = 6'd63;
                  state_in = ST_FIND;
               end
            end else begin
               row_in = row_ff + 7'd1;
            end
         end
         // Search the cofactor for its leading one.
         ST_FIND: begin
            if (status.e_bit || pos_ff == 6'd0) begin
               if (pos_ff == 6'd0) begin
                  state_in = ST_COF_END;
               end else begin
                  pos_in       = pos_ff - 6'd1;
                  mul_shift_in = 1'b0;
                  state_in     = ST_ROW_RD;
               end
            end else begin
               pos_in = pos_ff - 6'd1;
            end
         end
         ST_ROW_RD: begin
            cmd.acc_clr = 1'b1;
            state_in    = ST_ROW_LAT;
         end
         ST_ROW_LAT: begin
            cmd.op_latch = 1'b1;
            cmd.op_shift = mul_shift_ff;
            col_in       = '0;
            state_in     = ST_SCAN;
         end
         // Read one row of the old matrix each cycle.
         ST_SCAN: begin
            cmd.rd_row = col_ff[5:0];
            cmd.scan   = 1'b1;
            if (col_ff == n_last) begin
               state_in = ST_DRAIN;
            end else begin
               col_in = col_ff + 7'd1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_bank = ~bank_ff;
            if (row_ff == n_last) begin
               row_in   = '0;
               bank_in  = ~bank_ff;
               state_in = ST_AFTER;
            end else begin
               row_in   = row_ff + 7'd1;
               state_in = ST_ROW_RD;
            end
         end
         // Decide what follows a finished product.
         ST_AFTER: begin
            if (!cof_phase_ff) begin
               if (status.eq_first) begin
                  if (sq_ff != status.order) begin
                     verdict_in = VERDICT_EARLY;
                     state_in   = ST_RESULT;
                  end else if (status.cof_count > 7'd1) begin
                     k_in     = '0;
                     state_in = ST_COF_START;
                  end else begin
                     verdict_in = VERDICT_MAXIMAL;
                     state_in   = ST_RESULT;
                  end
               end else if (sq_ff == status.order) begin
                  verdict_in = VERDICT_NO_RETURN;
                  state_in   = ST_RESULT;
               end else begin
                  sq_in    = sq_ff + 7'd1;
                  state_in = ST_ROW_RD;
               end
            end else if (!mul_shift_ff && status.e_bit) begin
               mul_shift_in = 1'b1;
               state_in     = ST_ROW_RD;
            end else if (pos_ff == 6'd0) begin
               state_in = ST_COF_END;
            end else begin
               pos_in       = pos_ff - 6'd1;
               mul_shift_in = 1'b0;
               state_in     = ST_ROW_RD;
            end
         end
         ST_COF_START: begin
            cmd.e_load   = 1'b1;
            row_in       = '0;
            cof_phase_in = 1'b1;
            state_in     = ST_LOAD;
         end
         ST_COF_END: begin
            if (status.unit_row) begin
               verdict_in = VERDICT_COFACTOR;
               state_in   = ST_RESULT;
            end else if (k_ff + 7'd1 < status.cof_count) begin
               k_in     = k_ff + 7'd1;
               state_in = ST_COF_START;
            end else begin
               verdict_in = VERDICT_MAXIMAL;
               state_in   = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (status.slot_free) begin
               cmd.result_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

### rtl/core/lfsr_primitivity_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LFSR primitivity test: top level
// Decides whether an LFSR tap mask of the configured order is maximal length.
//
// Input channel (req_): command 0 clears the cofactor list, 1 appends a
// cofactor, 2 tests a tap mask. Clear and append take effect on the transfer
// and produce no result. A test produces one result on the rsp_ channel.
// Configuration: csr_write_enable writes the order register (reset 8).
// Speed: a GF(2) matrix product of order n is set by the single read port of
// the matrix memory, which delivers one row per cycle. A test loads the
// matrix and runs up to n products; with more than one cofactor, each cofactor
// adds a matrix load, a search for its leading one and up to two products per exponent bit.
// Throughput: one test at a time; req_stall is high while a test runs.
// Reset clears the cofactor list, the overflow flag and the result valid flag.
// A stalled result holds in the output register; the next item can still
// be accepted, and a later result waits until that register is free.
// ----------------------------------------------------------------------------
module lfsr_primitivity_test #(
   parameter int MAX_COFACTORS = 16
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire [1:0]  req_command,
   input  wire [63:0] req_value,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic       rsp_is_maximal,
   output logic [1:0] rsp_verdict,
   output logic [1:0] rsp_mirror_kind,
   output logic       rsp_table_overflow,
   input  wire        csr_write_enable,
   input  wire [6:0]  csr_write_data
);
   import lpt_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   lpt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .cmd         (dp_cmd),
      .status      (dp_status)
   );

   lpt_datapath #(
      .MAX_COFACTORS (MAX_COFACTORS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (dp_cmd),
      .status             (dp_status),
      .req_command        (req_command),
      .req_value          (req_value),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_is_maximal     (rsp_is_maximal),
      .rsp_verdict        (rsp_verdict),
      .rsp_mirror_kind    (rsp_mirror_kind),
      .rsp_table_overflow (rsp_table_overflow)
   );

   // A test transfer starts work, so the input stalls on the next cycle.
   a_test_busy : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_command == CMD_TEST) |=> req_stall)
      else $error("input not stalled after a test transfer");

   // A new result only appears at the end of a running test.
   a_result_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a running test");

   // The pass flag agrees with the verdict code.
   a_pass_flag : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_maximal == (rsp_verdict == VERDICT_MAXIMAL)))
      else $error("pass flag disagrees with verdict");

endmodule
`default_nettype wire

### tb/lfsr_primitivity_test_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LFSR primitivity test: self-checking testbench
// A queue-fed driver sends clear, append, test and unused commands with random gaps.
// A clocked monitor stalls the result channel at random and compares every
// result with a prediction made from a local GF(2) matrix model.
// ----------------------------------------------------------------------------
module lfsr_primitivity_test_tb;
   import lpt_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 1000000;
   localparam int HOLD_OFF = 8000;

   typedef struct {
      logic [1:0]  command;
      logic [63:0] value;
   } req_item_type;

   typedef struct {
      logic       is_maximal;
      logic [1:0] verdict;
      logic [1:0] mirror_kind;
      logic       table_overflow;
   } verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = CMD_CLEAR;
   logic [63:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_is_maximal;
   logic [1:0]  rsp_verdict;
   logic [1:0]  rsp_mirror_kind;
   logic        rsp_table_overflow;
   logic        csr_write_enable = 1'b0;
   logic [6:0]  csr_write_data = '0;

   // Pending commands and expected verdicts.
   req_item_type pending_cmds[$];
   verdict_type  expected_verdicts[$];

   // Local copy of the cofactor list and the order register.
   logic [63:0] cof_list[16];
   int          cof_total = 0;
   logic        cof_dropped = 1'b0;
   logic [6:0]  order_reg = ORDER_RESET;

   // Working matrices of the local model.
   logic [63:0] pow_m[64];
   logic [63:0] opd_m[64];
   logic [63:0] tmp_m[64];

   int          errors = 0;
   int          tests_sent = 0;
   int          results_seen = 0;
   int          verdict_hits[4] = '{0, 0, 0, 0};
   int          tx_gap = 0;
   int          rx_wait = 0;
   int          idle_cycles = 0;
   bit          no_idle = 1'b0;
   bit          held_off = 1'b0;

   lfsr_primitivity_test dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_is_maximal     (rsp_is_maximal),
      .rsp_verdict        (rsp_verdict),
      .rsp_mirror_kind    (rsp_mirror_kind),
      .rsp_table_overflow (rsp_table_overflow),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Row i of the one-shift companion matrix.
   function automatic logic [63:0] companion_row(int i, int n, logic [63:0] taps);
      logic [63:0] r;
      r = (i == n - 1) ? TOP_BIT : (TOP_BIT >> (i + 1));
      if (taps[i]) begin
         r = r | TOP_BIT;
      end
      return r;
   endfunction

   // pow_m = opd_m * pow_m over GF(2).
   function automatic void gf2_product(int n);
      logic [63:0] acc;
      for (int i = 0; i < n; i++) begin
         tmp_m[i] = pow_m[i];
      end
      for (int i = 0; i < n; i++) begin
         acc = '0;
         for (int j = 0; j < n; j++) begin
            if (opd_m[i][63-j]) begin
               acc = acc ^ tmp_m[j];
            end
         end
         pow_m[i] = acc;
      end
   endfunction

   function automatic void gf2_square(int n);
      for (int i = 0; i < n; i++) begin
         opd_m[i] = pow_m[i];
      end
      gf2_product(n);
   endfunction

   // Raise the companion matrix to the power e by square-and-multiply.
   function automatic void companion_power(logic [63:0] e, int n, logic [63:0] taps);
      int b;
      for (int i = 0; i < n; i++) begin
         pow_m[i] = companion_row(i, n, taps);
      end
      b = 63;
      while (b >= 0 && !e[b]) begin
         b--;
      end
      for (int k = b - 1; k >= 0; k--) begin
         gf2_square(n);
         if (e[k]) begin
            for (int i = 0; i < n; i++) begin
               opd_m[i] = companion_row(i, n, taps);
            end
            gf2_product(n);
         end
      end
   endfunction

   // Verdict of the squaring test and the cofactor checks.
   function automatic logic [1:0] period_verdict(int n, logic [63:0] taps);
      logic [63:0] first;
      for (int i = 0; i < n; i++) begin
         pow_m[i] = companion_row(i, n, taps);
      end
      first = pow_m[0];
      for (int i = 1; i <= n; i++) begin
         gf2_square(n);
         if (pow_m[0] == first) begin
            if (i != n) begin
               return VERDICT_EARLY;
            end
            if (cof_total > 1) begin
               for (int k = 0; k < cof_total; k++) begin
                  companion_power(cof_list[k], n, taps);
                  if (pow_m[0] == TOP_BIT) begin
                     return VERDICT_COFACTOR;
                  end
               end
            end
            return VERDICT_MAXIMAL;
         end
      end
      return VERDICT_NO_RETURN;
   endfunction

   // Compare each tap with its reciprocal partner.
   function automatic logic [1:0] reciprocal_kind(int n, logic [63:0] taps);
      for (int i = 1; i <= n / 2; i++) begin
         if (taps[i-1] != taps[n-i-1]) begin
            return taps[i-1] ? MIRROR_LOW_SET : MIRROR_LOW_CLEAR;
         end
      end
      return MIRROR_SYMMETRIC;
   endfunction

   // Apply one accepted command to the local state.
   function automatic void apply_command(logic [1:0] command, logic [63:0] value);
      verdict_type v;
      int n;
      n = int'(order_reg);
      if (n < 4) n = 4;
      if (n > 64) n = 64;
      case (command)
         CMD_CLEAR: begin
            cof_total = 0;
            cof_dropped = 1'b0;
         end
         CMD_APPEND: begin
            if (cof_total < 16) begin
               cof_list[cof_total] = value;
               cof_total++;
            end else begin
               cof_dropped = 1'b1;
            end
         end
         CMD_TEST: begin
            v.verdict = period_verdict(n, value);
            v.is_maximal = (v.verdict == VERDICT_MAXIMAL);
            v.mirror_kind = reciprocal_kind(n, value);
            v.table_overflow = cof_dropped;
            expected_verdicts.push_back(v);
            verdict_hits[v.verdict]++;
            tests_sent++;
         end
         default: begin
         end
      endcase
   endfunction

   // Driver: presents queued commands, with a random gap before each one.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_command(req_command, req_value);
         end
         if (!req_valid || !req_stall) begin
            if (tx_gap > 0) begin
               tx_gap = tx_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               req_command <= pending_cmds[0].command;
               req_value <= pending_cmds[0].value;
               void'(pending_cmds.pop_front());
               req_valid <= 1'b1;
               tx_gap = no_idle ? 0 : $urandom_range(0, 16);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result transfer and draws the next stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_verdicts.size() == 0) begin
               $display("%0t: unexpected result verdict=%0d", $time, rsp_verdict);
               errors++;
            end else begin
               if (rsp_is_maximal !== expected_verdicts[0].is_maximal) begin
                  $display("%0t: is_maximal expected %0d actual %0d", $time,
                           expected_verdicts[0].is_maximal, rsp_is_maximal);
                  errors++;
               end
               if (rsp_verdict !== expected_verdicts[0].verdict) begin
                  $display("%0t: verdict expected %0d actual %0d", $time,
                           expected_verdicts[0].verdict, rsp_verdict);
                  errors++;
               end
               if (rsp_mirror_kind !== expected_verdicts[0].mirror_kind) begin
                  $display("%0t: mirror_kind expected %0d actual %0d", $time,
                           expected_verdicts[0].mirror_kind, rsp_mirror_kind);
                  errors++;
               end
               if (rsp_table_overflow !== expected_verdicts[0].table_overflow) begin
                  $display("%0t: table_overflow expected %0d actual %0d", $time,
                           expected_verdicts[0].table_overflow, rsp_table_overflow);
                  errors++;
               end
               void'(expected_verdicts.pop_front());
            end
            // One long hold-off early on, so that the block fills and stalls.
            if (!held_off && results_seen == 3) begin
               held_off = 1'b1;
               rx_wait = HOLD_OFF;
            end else begin
               rx_wait = no_idle ? 0 : $urandom_range(0, 16);
            end
         end
         if (rx_wait > 0) begin
            rx_wait = rx_wait - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("lfsr_primitivity_test_tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic queue_cmd(logic [1:0] command, logic [63:0] value);
      req_item_type it;
      it.command = command;
      it.value = value;
      pending_cmds.push_back(it);
   endtask

   // Wait until every command is sent and every result is back.
   task automatic wait_drained();
      while (pending_cmds.size() > 0 || req_valid || expected_verdicts.size() > 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
   endtask

   task automatic write_order(logic [6:0] value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      order_reg = value;
   endtask

   // A random mix weighted toward tests, with clear-then-append sequences, single appends and unused commands.
   task automatic queue_random(int count, int n);
      int r;
      logic [63:0] lim;
      lim = 64'd1 << n;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 20) begin
            queue_cmd(CMD_CLEAR, {$urandom, $urandom});
            repeat ($urandom_range(2, 4)) begin
               if ($urandom_range(0, 9) == 0) begin
                  queue_cmd(CMD_APPEND, {$urandom, $urandom});
               end else begin
                  queue_cmd(CMD_APPEND, 64'($urandom_range(0, 32'(lim))));
               end
            end
         end else if (r < 28) begin
            queue_cmd(CMD_APPEND, 64'($urandom_range(0, 32'(lim))));
         end else if (r < 31) begin
            queue_cmd(CMD_UNUSED, {$urandom, $urandom});
         end else begin
            queue_cmd(CMD_TEST, {$urandom, $urandom});
         end
      end
   endtask

   initial begin
      int n;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset order, cofactor lists, zero and single cofactors.
      queue_cmd(CMD_CLEAR, '0);
      queue_cmd(CMD_TEST, 64'hB8);
      queue_cmd(CMD_TEST, '1);
      queue_cmd(CMD_TEST, '0);
      queue_cmd(CMD_APPEND, 64'd85);
      queue_cmd(CMD_APPEND, 64'd51);
      queue_cmd(CMD_APPEND, 64'd15);
      queue_cmd(CMD_TEST, 64'hB8);
      queue_cmd(CMD_TEST, 64'hFFFF_FFFF_FFFF_FF8E);
      queue_cmd(CMD_UNUSED, 64'hB8);
      queue_cmd(CMD_APPEND, 64'd0);
      queue_cmd(CMD_TEST, 64'hB8);
      queue_cmd(CMD_CLEAR, '0);
      queue_cmd(CMD_APPEND, 64'd255);
      queue_cmd(CMD_TEST, 64'hB8);
      repeat (16) queue_cmd(CMD_APPEND, 64'd3);
      queue_cmd(CMD_TEST, 64'h71);
      queue_cmd(CMD_CLEAR, '0);
      queue_cmd(CMD_TEST, 64'h1D);

      // Order below range clamps to the smallest length.
      write_order(7'd0);
      queue_cmd(CMD_TEST, 64'hAAAA_5555_0000_0009);
      queue_cmd(CMD_APPEND, 64'd5);
      queue_cmd(CMD_APPEND, 64'd15);
      queue_cmd(CMD_TEST, 64'h9);
      queue_cmd(CMD_TEST, 64'hC);
      queue_cmd(CMD_CLEAR, '0);

      // Order above range clamps to the largest length, once.
      write_order(7'd127);
      queue_cmd(CMD_TEST, {$urandom, $urandom});

      // Random phases at small orders, one of them without idling.
      for (int p = 0; p < 5; p++) begin
         n = (p == 0) ? 4 : $urandom_range(4, 10);
         write_order(7'(n));
         no_idle = (p == 2);
         queue_random(10, n);
      end
      wait_drained();
      no_idle = 1'b0;
      repeat (100) @(posedge clock);

      $display("Ran %0d tap tests, %0d results checked; verdicts seen 0:%0d 1:%0d 2:%0d 3:%0d.",
               tests_sent, results_seen, verdict_hits[0], verdict_hits[1],
               verdict_hits[2], verdict_hits[3]);
      $display("Orders covered: reset value, clamped low and high, random 4 to 10.");
      if (errors == 0 && expected_verdicts.size() == 0) begin
         $display("lfsr_primitivity_test_tb: done, clean");
      end else begin
         $display("lfsr_primitivity_test_tb: done, errors");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/lpt_pkg.sv
rtl/core/lpt_datapath.sv
rtl/core/lpt_ctrl.sv
rtl/core/lfsr_primitivity_test.sv
tb/lfsr_primitivity_test_tb.sv
